>>> sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and types for the triangle unit normal pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

   localparam int COORD_WIDTH_DEF      = 24;
   localparam int NORMAL_FRAC_BITS_DEF = 30;
   localparam int NORMAL_WIDTH         = 32;
   localparam int LANES                = 3;

   // control that travels with each item down the pipe
   typedef struct packed {
      logic             valid;
      logic             degenerate;
      logic [LANES-1:0] neg;
   } ctl_type;

endpackage

`default_nettype wire

>>> sv/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// Edge vectors, exact cross product, component squares and their sum.
// Six register stages; one item per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_front #(
   parameter int  COORD_WIDTH = tun_pkg::COORD_WIDTH_DEF,
   localparam int SQ_WIDTH    = 4*COORD_WIDTH + 4,
   localparam int SUM_WIDTH   = 4*COORD_WIDTH + 6
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  in_valid,
   input  wire logic [2:0][COORD_WIDTH-1:0]           v0,
   input  wire logic [2:0][COORD_WIDTH-1:0]           v1,
   input  wire logic [2:0][COORD_WIDTH-1:0]           v2,
   output tun_pkg::ctl_type                           ctl_out,
   output logic [2:0][SQ_WIDTH-1:0]                   csq_out,
   output logic [SUM_WIDTH-1:0]                       sum_out
);

   localparam int EW = COORD_WIDTH + 1;     // edge
   localparam int PW = 2*EW;                // product
   localparam int XW = PW + 1;              // cross term
   localparam int MW = 2*COORD_WIDTH + 2;   // cross magnitude
   localparam int H  = (MW + 1) / 2;        // low half for squaring
   localparam int HW = MW - H;              // high half

   tun_pkg::ctl_type a_ctl_ff, b_ctl_ff, c_ctl_ff, d_ctl_ff, e_ctl_ff, f_ctl_ff;
   tun_pkg::ctl_type a_ctl_in, c_ctl_in, f_ctl_in;

   logic signed [EW-1:0] ea_ff [3];
   logic signed [EW-1:0] eb_ff [3];
   logic signed [EW-1:0] ea_in [3];
   logic signed [EW-1:0] eb_in [3];

   logic signed [PW-1:0] pp_ff [3];
   logic signed [PW-1:0] pq_ff [3];
   logic signed [PW-1:0] pp_in [3];
   logic signed [PW-1:0] pq_in [3];

   logic [MW-1:0] mag_ff [3];
   logic [MW-1:0] mag_in [3];
   logic [2:0]    neg_in;

   logic [2*HW-1:0]   hh_ff [3];
   logic [HW+H-1:0]   hl_ff [3];
   logic [2*H-1:0]    ll_ff [3];
   logic [2*HW-1:0]   hh_in [3];
   logic [HW+H-1:0]   hl_in [3];
   logic [2*H-1:0]    ll_in [3];

   logic [2:0][SQ_WIDTH-1:0] csq_e_ff, csq_e_in, csq_f_ff;
   logic [SUM_WIDTH-1:0]     sum_f_ff, sum_f_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ea_in[i] = $signed({v1[i][COORD_WIDTH-1], v1[i]}) -
                    $signed({v0[i][COORD_WIDTH-1], v0[i]});
         eb_in[i] = $signed({v2[i][COORD_WIDTH-1], v2[i]}) -
                    $signed({v0[i][COORD_WIDTH-1], v0[i]});
      end
   end

   always_comb begin
      pp_in[0] = PW'(ea_ff[1]) * PW'(eb_ff[2]);
      pq_in[0] = PW'(ea_ff[2]) * PW'(eb_ff[1]);
      pp_in[1] = PW'(ea_ff[2]) * PW'(eb_ff[0]);
      pq_in[1] = PW'(ea_ff[0]) * PW'(eb_ff[2]);
      pp_in[2] = PW'(ea_ff[0]) * PW'(eb_ff[1]);
      pq_in[2] = PW'(ea_ff[1]) * PW'(eb_ff[0]);
   end

   always_comb begin
      logic signed [XW-1:0] x;
      for (int i = 0; i < 3; i++) begin
         x         = XW'(pp_ff[i]) - XW'(pq_ff[i]);
         neg_in[i] = x[XW-1];
         mag_in[i] = x[XW-1] ? MW'(-x) : MW'(x);
      end
   end

   // split squaring into three half-width products
   always_comb begin
      logic [HW-1:0] hi;
      logic [H-1:0]  lo;
      for (int i = 0; i < 3; i++) begin
         hi       = mag_ff[i][MW-1:H];
         lo       = mag_ff[i][H-1:0];
         hh_in[i] = (2*HW)'(hi) * (2*HW)'(hi);
         hl_in[i] = (HW+H)'(hi) * (HW+H)'(lo);
         ll_in[i] = (2*H)'(lo) * (2*H)'(lo);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         csq_e_in[i] = (SQ_WIDTH'(hh_ff[i]) << (2*H)) +
                       (SQ_WIDTH'(hl_ff[i]) << (H+1)) +
                       SQ_WIDTH'(ll_ff[i]);
      end
      sum_f_in = SUM_WIDTH'(csq_e_ff[0]) + SUM_WIDTH'(csq_e_ff[1]) +
                 SUM_WIDTH'(csq_e_ff[2]);
   end

   always_comb begin
      a_ctl_in            = '0;
      a_ctl_in.valid      = in_valid;
      c_ctl_in            = b_ctl_ff;
      c_ctl_in.neg        = neg_in;
      f_ctl_in            = e_ctl_ff;
      f_ctl_in.degenerate = (sum_f_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
         c_ctl_ff <= '0;
         d_ctl_ff <= '0;
         e_ctl_ff <= '0;
         f_ctl_ff <= '0;
      end else begin
         a_ctl_ff <= a_ctl_in;
         b_ctl_ff <= a_ctl_ff;
         c_ctl_ff <= c_ctl_in;
         d_ctl_ff <= c_ctl_ff;
         e_ctl_ff <= d_ctl_ff;
         f_ctl_ff <= f_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         ea_ff[i]  <= ea_in[i];
         eb_ff[i]  <= eb_in[i];
         pp_ff[i]  <= pp_in[i];
         pq_ff[i]  <= pq_in[i];
         mag_ff[i] <= mag_in[i];
         hh_ff[i]  <= hh_in[i];
         hl_ff[i]  <= hl_in[i];
         ll_ff[i]  <= ll_in[i];
      end
      csq_e_ff <= csq_e_in;
      csq_f_ff <= csq_e_ff;
      sum_f_ff <= sum_f_in;
   end

   assign ctl_out = f_ctl_ff;
   assign csq_out = csq_f_ff;
   assign sum_out = sum_f_ff;

endmodule

`default_nettype wire

>>> sv/tun_div_stage.sv
// ----------------------------------------------------------------------------
// tun_div_stage
// One restoring-division step on three lanes: one quotient bit per lane.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_div_stage #(
   parameter int SUM_WIDTH = 4*tun_pkg::COORD_WIDTH_DEF + 6,
   parameter int QUO_WIDTH = 2*tun_pkg::NORMAL_FRAC_BITS_DEF + 3,
   parameter bit FIRST     = 1'b0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tun_pkg::ctl_type                  ctl_in,
   input  wire logic [SUM_WIDTH-1:0]              sum_in,
   input  wire logic [2:0][SUM_WIDTH-1:0]         rem_in,
   input  wire logic [2:0][QUO_WIDTH-1:0]         quo_in,
   output tun_pkg::ctl_type                       ctl_out,
   output logic [SUM_WIDTH-1:0]                   sum_out,
   output logic [2:0][SUM_WIDTH-1:0]              rem_out,
   output logic [2:0][QUO_WIDTH-1:0]              quo_out
);

   tun_pkg::ctl_type              ctl_ff;
   logic [SUM_WIDTH-1:0]          sum_ff;
   logic [2:0][SUM_WIDTH-1:0]     rem_ff, rem_nx_in;
   logic [2:0][QUO_WIDTH-1:0]     quo_ff, quo_nx_in;

   always_comb begin
      logic [SUM_WIDTH:0] t;
      logic               ge;
      for (int i = 0; i < 3; i++) begin
         t  = FIRST ? {1'b0, rem_in[i]} : {rem_in[i], 1'b0};
         ge = (t >= {1'b0, sum_in});
         rem_nx_in[i] = ge ? SUM_WIDTH'(t - {1'b0, sum_in}) : SUM_WIDTH'(t);
         quo_nx_in[i] = {quo_in[i][QUO_WIDTH-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      rem_ff <= rem_nx_in;
      quo_ff <= quo_nx_in;
   end

   assign ctl_out = ctl_ff;
   assign sum_out = sum_ff;
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;

endmodule

`default_nettype wire

>>> sv/tun_sqrt_stage.sv
// ----------------------------------------------------------------------------
// tun_sqrt_stage
// One digit-by-digit integer square root step on three lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_sqrt_stage #(
   parameter int RAD_WIDTH  = 2*tun_pkg::NORMAL_FRAC_BITS_DEF + 4,
   parameter int ROOT_WIDTH = tun_pkg::NORMAL_FRAC_BITS_DEF + 2
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire tun_pkg::ctl_type                  ctl_in,
   input  wire logic [2:0][RAD_WIDTH-1:0]         rad_in,
   input  wire logic [2:0][ROOT_WIDTH-1:0]        root_in,
   input  wire logic [2:0][ROOT_WIDTH+1:0]        rem_in,
   output tun_pkg::ctl_type                       ctl_out,
   output logic [2:0][RAD_WIDTH-1:0]              rad_out,
   output logic [2:0][ROOT_WIDTH-1:0]             root_out,
   output logic [2:0][ROOT_WIDTH+1:0]             rem_out
);

   tun_pkg::ctl_type               ctl_ff;
   logic [2:0][RAD_WIDTH-1:0]      rad_ff, rad_nx_in;
   logic [2:0][ROOT_WIDTH-1:0]     root_ff, root_nx_in;
   logic [2:0][ROOT_WIDTH+1:0]     rem_ff, rem_nx_in;

   always_comb begin
      logic [ROOT_WIDTH+3:0] cur;
      logic [ROOT_WIDTH+3:0] trial;
      logic                  ge;
      for (int i = 0; i < 3; i++) begin
         cur   = {rem_in[i], rad_in[i][RAD_WIDTH-1:RAD_WIDTH-2]};
         trial = {2'b00, root_in[i], 2'b01};
         ge    = (cur >= trial);
         rem_nx_in[i]  = ge ? (ROOT_WIDTH+2)'(cur - trial) : (ROOT_WIDTH+2)'(cur);
         root_nx_in[i] = {root_in[i][ROOT_WIDTH-2:0], ge};
         rad_nx_in[i]  = {rad_in[i][RAD_WIDTH-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_nx_in;
      root_ff <= root_nx_in;
      rem_ff  <= rem_nx_in;
   end

   assign ctl_out  = ctl_ff;
   assign rad_out  = rad_ff;
   assign root_out = root_ff;
   assign rem_out  = rem_ff;

endmodule

`default_nettype wire

>>> sv/triangle_unit_normal_top.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_top
// Unit face normal of a triangle in signed Q1.F, exact and rounded to nearest.
//
// Input: the nine vertex coordinates on req_* ports, transferred at a clock
// edge with start high and busy low. busy is always low: a new triangle may be
// given every cycle.
// Output: one result per triangle on rsp_normal_x/y/z and rsp_degenerate,
// shown for one cycle with rsp_strobe high; the receiver cannot stall.
// The pipeline has six front stages
// (edges, products, cross terms, partial squares, squares, sum), 2F+3
// restoring-division steps for c^2 * 2^(2F+2) / |c|^2, F+2 square root steps,
// and one rounding stage. Throughput is one triangle per cycle.
// A zero cross product gives a zero normal with rsp_degenerate set.
// Synchronous reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_unit_normal_top #(
   parameter int COORD_WIDTH      = tun_pkg::COORD_WIDTH_DEF,
   parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic signed [COORD_WIDTH-1:0]            req_first_x,
   input  wire logic signed [COORD_WIDTH-1:0]            req_first_y,
   input  wire logic signed [COORD_WIDTH-1:0]            req_first_z,
   input  wire logic signed [COORD_WIDTH-1:0]            req_second_x,
   input  wire logic signed [COORD_WIDTH-1:0]            req_second_y,
   input  wire logic signed [COORD_WIDTH-1:0]            req_second_z,
   input  wire logic signed [COORD_WIDTH-1:0]            req_third_x,
   input  wire logic signed [COORD_WIDTH-1:0]            req_third_y,
   input  wire logic signed [COORD_WIDTH-1:0]            req_third_z,
   output logic                                          rsp_strobe,
   output logic signed [tun_pkg::NORMAL_WIDTH-1:0]       rsp_normal_x,
   output logic signed [tun_pkg::NORMAL_WIDTH-1:0]       rsp_normal_y,
   output logic signed [tun_pkg::NORMAL_WIDTH-1:0]       rsp_normal_z,
   output logic                                          rsp_degenerate
);

   localparam int NW       = tun_pkg::NORMAL_WIDTH;
   localparam int SQW      = 4*COORD_WIDTH + 4;
   localparam int SW       = 4*COORD_WIDTH + 6;
   localparam int QB       = 2*NORMAL_FRAC_BITS + 3;
   localparam int QP       = QB + 1;
   localparam int RB       = NORMAL_FRAC_BITS + 2;
   localparam int LATENCY  = 6 + QB + RB + 1;

   tun_pkg::ctl_type          front_ctl;
   logic [2:0][SQW-1:0]       front_csq;
   logic [SW-1:0]             front_sum;

   tun_pkg::ctl_type          div_ctl [QB+1];
   logic [SW-1:0]             div_sum [QB+1];
   logic [2:0][SW-1:0]        div_rem [QB+1];
   logic [2:0][QB-1:0]        div_quo [QB+1];

   tun_pkg::ctl_type          sq_ctl  [RB+1];
   logic [2:0][QP-1:0]        sq_rad  [RB+1];
   logic [2:0][RB-1:0]        sq_root [RB+1];
   logic [2:0][RB+1:0]        sq_rem  [RB+1];

   tun_pkg::ctl_type          out_ctl_ff;
   logic [2:0][NW-1:0]        out_nrm_ff, out_nrm_in;

   assign busy = 1'b0;

   tun_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start & ~busy),
      .v0       ({req_first_z,  req_first_y,  req_first_x}),
      .v1       ({req_second_z, req_second_y, req_second_x}),
      .v2       ({req_third_z,  req_third_y,  req_third_x}),
      .ctl_out  (front_ctl),
      .csq_out  (front_csq),
      .sum_out  (front_sum)
   );

   assign div_ctl[0] = front_ctl;
   assign div_sum[0] = front_sum;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         div_rem[0][i] = SW'(front_csq[i]);
         div_quo[0][i] = '0;
      end
   end

   // first step compares without doubling, since c^2 <= |c|^2
   for (genvar k = 0; k < QB; k++) begin : g_div
      tun_div_stage #(
         .SUM_WIDTH (SW),
         .QUO_WIDTH (QB),
         .FIRST     (k == 0)
      ) u_div (
         .clock   (clock),
         .reset   (reset),
         .ctl_in  (div_ctl[k]),
         .sum_in  (div_sum[k]),
         .rem_in  (div_rem[k]),
         .quo_in  (div_quo[k]),
         .ctl_out (div_ctl[k+1]),
         .sum_out (div_sum[k+1]),
         .rem_out (div_rem[k+1]),
         .quo_out (div_quo[k+1])
      );
   end

   assign sq_ctl[0] = div_ctl[QB];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_rad[0][i]  = {1'b0, div_quo[QB][i]};
         sq_root[0][i] = '0;
         sq_rem[0][i]  = '0;
      end
   end

   for (genvar k = 0; k < RB; k++) begin : g_sqrt
      tun_sqrt_stage #(
         .RAD_WIDTH  (QP),
         .ROOT_WIDTH (RB)
      ) u_sqrt (
         .clock    (clock),
         .reset    (reset),
         .ctl_in   (sq_ctl[k]),
         .rad_in   (sq_rad[k]),
         .root_in  (sq_root[k]),
         .rem_in   (sq_rem[k]),
         .ctl_out  (sq_ctl[k+1]),
         .rad_out  (sq_rad[k+1]),
         .root_out (sq_root[k+1]),
         .rem_out  (sq_rem[k+1])
      );
   end

   // largest m with (2m-1)^2 <= Q is (isqrt(Q)+1)/2
   always_comb begin
      logic [RB:0]   m;
      logic [NW-1:0] v;
      for (int i = 0; i < 3; i++) begin
         m = ({1'b0, sq_root[RB][i]} + (RB+1)'(1)) >> 1;
         v = NW'(m);
         if (sq_ctl[RB].degenerate) begin
            out_nrm_in[i] = '0;
         end else if (sq_ctl[RB].neg[i]) begin
            out_nrm_in[i] = -v;
         end else begin
            out_nrm_in[i] = v;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else begin
         out_ctl_ff <= sq_ctl[RB];
      end
   end

   always_ff @(posedge clock) begin
      out_nrm_ff <= out_nrm_in;
   end

   assign rsp_strobe     = out_ctl_ff.valid;
   assign rsp_normal_x   = $signed(out_nrm_ff[0]);
   assign rsp_normal_y   = $signed(out_nrm_ff[1]);
   assign rsp_normal_z   = $signed(out_nrm_ff[2]);
   assign rsp_degenerate = out_ctl_ff.degenerate;

   localparam logic signed [NW-1:0] UNIT = $signed(NW'(1) << NORMAL_FRAC_BITS);

   a_latency : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("result strobe missing after fixed latency");

   a_degen_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_degenerate) |->
         (rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0))
      else $error("degenerate triangle with nonzero normal");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (rsp_normal_x <= UNIT && rsp_normal_x >= -UNIT &&
          rsp_normal_y <= UNIT && rsp_normal_y >= -UNIT &&
          rsp_normal_z <= UNIT && rsp_normal_z >= -UNIT))
      else $error("normal component outside unit range");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching request");

endmodule

`default_nettype wire
